FILE: hdl/mst_pkg.sv
package mst_pkg;

    localparam int unsigned MAX_TEXT_LENGTH = 65536;
    localparam int unsigned POS_W           = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int unsigned RESULT_DEPTH    = 4;
    localparam int unsigned RESULT_PTR_W    = $clog2(RESULT_DEPTH);
    localparam int unsigned RESULT_CNT_W    = $clog2(RESULT_DEPTH + 1);
    localparam int unsigned PUSH_MAX        = 2;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_WORD,
        MODE_COMMENT,
        MODE_ERROR
    } lex_mode_t;

    typedef enum logic [4:0] {
        KIND_NUM      = 5'd0,
        KIND_LET      = 5'd1,
        KIND_ID       = 5'd2,
        KIND_EQUALS   = 5'd3,
        KIND_RAND     = 5'd4,
        KIND_ADD      = 5'd5,
        KIND_SUB      = 5'd6,
        KIND_DIV      = 5'd7,
        KIND_MUL      = 5'd8,
        KIND_LBRACKET = 5'd9,
        KIND_RBRACKET = 5'd10,
        KIND_COMMA    = 5'd11,
        KIND_LPAREN   = 5'd12,
        KIND_RPAREN   = 5'd13,
        KIND_PATTERN  = 5'd14,
        KIND_END      = 5'd15,
        KIND_ERROR    = 5'd16
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_UNEXPECTED,
        ERR_UNCLOSED,
        ERR_OVERFLOW
    } error_code_t;

    typedef struct packed {
        token_kind_t kind;
        logic [30:0] value;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        error_code_t error_code;
        logic [7:0]  bad_char;
        logic        last;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return (c == "=") || (c == "+") || (c == "-") || (c == "/") || (c == "*") ||
               (c == "[") || (c == "]") || (c == ",") || (c == "(") || (c == ")");
    endfunction

    function automatic token_kind_t symbol_kind(input logic [7:0] c);
        token_kind_t k;
        case (c)
            "=":     k = KIND_EQUALS;
            "+":     k = KIND_ADD;
            "-":     k = KIND_SUB;
            "/":     k = KIND_DIV;
            "*":     k = KIND_MUL;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            ",":     k = KIND_COMMA;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            default: k = KIND_ID;
        endcase
        return k;
    endfunction

    // bit 0 pattern, bit 1 rand, bit 2 let: does c match the keyword at index idx
    function automatic logic [2:0] keyword_hits(input logic [3:0] idx, input logic [7:0] c);
        logic [2:0] h;
        case (idx)
            4'd0:    h = {c == "l", c == "r", c == "p"};
            4'd1:    h = {c == "e", c == "a", c == "a"};
            4'd2:    h = {c == "t", c == "n", c == "t"};
            4'd3:    h = {1'b0, c == "d", c == "t"};
            4'd4:    h = {2'b00, c == "e"};
            4'd5:    h = {2'b00, c == "r"};
            4'd6:    h = {2'b00, c == "n"};
            default: h = 3'b000;
        endcase
        return h;
    endfunction

    function automatic token_kind_t word_kind(input logic [2:0] cands, input logic [3:0] len);
        token_kind_t k;
        if (cands[0] && (len == 4'd7))
            k = KIND_PATTERN;
        else if (cands[1] && (len == 4'd4))
            k = KIND_RAND;
        else if (cands[2] && (len == 4'd3))
            k = KIND_LET;
        else
            k = KIND_ID;
        return k;
    endfunction

    function automatic result_t make_result(
        input token_kind_t kind,
        input logic [30:0] value,
        input logic [15:0] start_pos,
        input logic [15:0] end_pos,
        input error_code_t err,
        input logic [7:0]  bad,
        input logic        last
    );
        result_t r;
        r.kind       = kind;
        r.value      = value;
        r.start_pos  = start_pos;
        r.end_pos    = end_pos;
        r.error_code = err;
        r.bad_char   = bad;
        r.last       = last;
        return r;
    endfunction

endpackage

FILE: hdl/mst_lexer.sv
module mst_lexer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              command,
    input  logic [7:0]        char_code,
    output mst_pkg::result_t  res [mst_pkg::PUSH_MAX],
    output logic [1:0]        push_cnt
);

    mst_pkg::lex_mode_t      mode_reg, mode_next;
    logic [mst_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]             tok_start_reg, tok_start_next;
    logic [30:0]             acc_reg, acc_next;
    logic                    ovf_reg, ovf_next;
    logic [3:0]              wlen_reg, wlen_next;
    logic [2:0]              cands_reg, cands_next;
    mst_pkg::error_code_t    latched_reg, latched_next;

    logic [15:0] p_lo;
    logic [15:0] p_prev;
    logic [34:0] acc_x10;
    logic [3:0]  digit;
    logic        classify;

    assign p_lo    = 16'(pos_reg);
    assign p_prev  = p_lo - 16'd1;
    assign digit   = 4'(char_code - mst_pkg::CHAR_ZERO);
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 35'(digit);

    always_comb
    begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        tok_start_next = tok_start_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        wlen_next      = wlen_reg;
        cands_next     = cands_reg;
        latched_next   = latched_reg;
        res[0]         = '0;
        res[1]         = '0;
        push_cnt       = 2'd0;
        classify       = 1'b0;

        if (fire && command)
        begin
            // finish: flush what is pending, then the end beat
            if (mode_reg == mst_pkg::MODE_COMMENT)
            begin
                latched_next = mst_pkg::ERR_UNCLOSED;
                res[0] = mst_pkg::make_result(mst_pkg::KIND_ERROR, '0, tok_start_reg, p_prev,
                                              mst_pkg::ERR_UNCLOSED, '0, 1'b0);
                push_cnt = 2'd1;
            end
            else if (mode_reg == mst_pkg::MODE_NUM)
            begin
                if (ovf_reg)
                begin
                    latched_next = mst_pkg::ERR_OVERFLOW;
                    res[0] = mst_pkg::make_result(mst_pkg::KIND_ERROR, '0, tok_start_reg,
                                                  p_prev, mst_pkg::ERR_OVERFLOW, '0, 1'b0);
                end
                else
                begin
                    res[0] = mst_pkg::make_result(mst_pkg::KIND_NUM, acc_reg, tok_start_reg,
                                                  p_prev, mst_pkg::ERR_NONE, '0, 1'b0);
                end
                push_cnt = 2'd1;
            end
            else if (mode_reg == mst_pkg::MODE_WORD)
            begin
                res[0] = mst_pkg::make_result(mst_pkg::word_kind(cands_reg, wlen_reg), '0,
                                              tok_start_reg, p_prev, mst_pkg::ERR_NONE,
                                              '0, 1'b0);
                push_cnt = 2'd1;
            end
            res[push_cnt[0]] = mst_pkg::make_result(mst_pkg::KIND_END, '0, p_lo, p_lo,
                                                    latched_next, '0, 1'b1);
            push_cnt       = push_cnt + 2'd1;
            mode_next      = mst_pkg::MODE_IDLE;
            pos_next       = '0;
            tok_start_next = '0;
            acc_next       = '0;
            ovf_next       = 1'b0;
            wlen_next      = '0;
            cands_next     = 3'b111;
            latched_next   = mst_pkg::ERR_NONE;
        end
        else if (fire && (pos_reg < mst_pkg::POS_W'(mst_pkg::MAX_TEXT_LENGTH)))
        begin
            pos_next = pos_reg + mst_pkg::POS_W'(1);
            case (mode_reg)
                mst_pkg::MODE_ERROR:
                begin
                end
                mst_pkg::MODE_COMMENT:
                begin
                    if (char_code == mst_pkg::CHAR_DOLLAR)
                        mode_next = mst_pkg::MODE_IDLE;
                end
                mst_pkg::MODE_NUM:
                begin
                    if (mst_pkg::is_digit(char_code))
                    begin
                        if (!ovf_reg)
                        begin
                            if (acc_x10 > 35'(mst_pkg::NUM_MAX))
                                ovf_next = 1'b1;
                            else
                                acc_next = acc_x10[30:0];
                        end
                    end
                    else if (ovf_reg)
                    begin
                        // the character ending an overflowed run is dropped
                        latched_next = mst_pkg::ERR_OVERFLOW;
                        mode_next    = mst_pkg::MODE_ERROR;
                        res[0] = mst_pkg::make_result(mst_pkg::KIND_ERROR, '0, tok_start_reg,
                                                      p_prev, mst_pkg::ERR_OVERFLOW, '0, 1'b0);
                        push_cnt = 2'd1;
                    end
                    else
                    begin
                        mode_next = mst_pkg::MODE_IDLE;
                        res[0] = mst_pkg::make_result(mst_pkg::KIND_NUM, acc_reg, tok_start_reg,
                                                      p_prev, mst_pkg::ERR_NONE, '0, 1'b0);
                        push_cnt = 2'd1;
                        classify = 1'b1;
                    end
                end
                mst_pkg::MODE_WORD:
                begin
                    if (mst_pkg::is_alpha(char_code) || mst_pkg::is_digit(char_code))
                    begin
                        cands_next = cands_reg & mst_pkg::keyword_hits(wlen_reg, char_code);
                        if (wlen_reg != 4'd15)
                            wlen_next = wlen_reg + 4'd1;
                    end
                    else
                    begin
                        mode_next = mst_pkg::MODE_IDLE;
                        res[0] = mst_pkg::make_result(mst_pkg::word_kind(cands_reg, wlen_reg),
                                                      '0, tok_start_reg, p_prev,
                                                      mst_pkg::ERR_NONE, '0, 1'b0);
                        push_cnt = 2'd1;
                        classify = 1'b1;
                    end
                end
                default:
                begin
                    classify = 1'b1;
                end
            endcase

            if (classify)
            begin
                if (mst_pkg::is_space(char_code))
                begin
                end
                else if (char_code == mst_pkg::CHAR_DOLLAR)
                begin
                    mode_next      = mst_pkg::MODE_COMMENT;
                    tok_start_next = p_lo;
                end
                else if (mst_pkg::is_digit(char_code))
                begin
                    mode_next      = mst_pkg::MODE_NUM;
                    tok_start_next = p_lo;
                    acc_next       = 31'(digit);
                    ovf_next       = 1'b0;
                end
                else if (mst_pkg::is_alpha(char_code))
                begin
                    mode_next      = mst_pkg::MODE_WORD;
                    tok_start_next = p_lo;
                    wlen_next      = 4'd1;
                    cands_next     = mst_pkg::keyword_hits(4'd0, char_code);
                end
                else if (mst_pkg::is_symbol(char_code))
                begin
                    res[push_cnt[0]] = mst_pkg::make_result(mst_pkg::symbol_kind(char_code),
                                                            '0, p_lo, p_lo, mst_pkg::ERR_NONE,
                                                            '0, 1'b0);
                    push_cnt = push_cnt + 2'd1;
                end
                else
                begin
                    mode_next    = mst_pkg::MODE_ERROR;
                    latched_next = mst_pkg::ERR_UNEXPECTED;
                    res[push_cnt[0]] = mst_pkg::make_result(mst_pkg::KIND_ERROR, '0, p_lo, p_lo,
                                                            mst_pkg::ERR_UNEXPECTED, char_code,
                                                            1'b0);
                    push_cnt = push_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mst_pkg::MODE_IDLE;
            pos_reg       <= '0;
            tok_start_reg <= '0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            wlen_reg      <= '0;
            cands_reg     <= 3'b111;
            latched_reg   <= mst_pkg::ERR_NONE;
        end
        else
        begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            tok_start_reg <= tok_start_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            wlen_reg      <= wlen_next;
            cands_reg     <= cands_next;
            latched_reg   <= latched_next;
        end
    end

endmodule

FILE: hdl/mst_result_fifo.sv
module mst_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  mst_pkg::result_t  push_data [mst_pkg::PUSH_MAX],
    input  logic [1:0]        push_cnt,
    input  logic              pop,
    output logic              not_empty,
    output logic              room,
    output mst_pkg::result_t  head
);

    mst_pkg::result_t mem_reg [mst_pkg::RESULT_DEPTH];
    logic [mst_pkg::RESULT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mst_pkg::RESULT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mst_pkg::RESULT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [mst_pkg::RESULT_PTR_W-1:0] wr_ptr_plus1;
    logic             do_pop;

    assign not_empty    = (cnt_reg != '0);
    assign room         = (cnt_reg <= mst_pkg::RESULT_CNT_W'(mst_pkg::RESULT_DEPTH -
                                                              mst_pkg::PUSH_MAX));
    assign head         = mem_reg[rd_ptr_reg];
    assign do_pop       = pop && not_empty;
    assign wr_ptr_plus1 = wr_ptr_reg + mst_pkg::RESULT_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + mst_pkg::RESULT_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + mst_pkg::RESULT_PTR_W'(do_pop);
        cnt_next    = cnt_reg + mst_pkg::RESULT_CNT_W'(push_cnt)
                              - mst_pkg::RESULT_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= push_data[0];
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_plus1] <= push_data[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: hdl/music_script_tokenizer.sv
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------------
// input    | in_valid / in_stall | command, char_code
// output   | out_valid/out_stall | token_kind, number_value, start_pos, end_pos,
//          |                     | error_code, bad_char, last
//
// one character per cycle while the buffer has room; a beat sits in the input register,
// the lexer handles it and writes zero to two records into a four-entry result buffer.
// a beat is registered in the input register and its records in the buffer before they leave.
// the lexer works only when the buffer has room for two records, so the output
// side sets the rate: at most one record leaves per cycle.
// reset puts the lexer in idle at position zero and empties the buffer.
module music_script_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [30:0] number_value,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [1:0]  error_code,
    output logic [7:0]  bad_char,
    output logic        last
);

    logic       in_valid_reg, in_valid_next;
    logic       cmd_reg;
    logic [7:0] char_reg;
    logic       fire;
    logic       room;
    logic       accept;
    logic [1:0] push_cnt;

    mst_pkg::result_t res [mst_pkg::PUSH_MAX];
    mst_pkg::result_t head;

    assign fire     = in_valid_reg && room;
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            char_reg <= char_code;
        end
    end

    mst_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .command   (cmd_reg),
        .char_code (char_reg),
        .res       (res),
        .push_cnt  (push_cnt)
    );

    mst_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_data (res),
        .push_cnt  (push_cnt),
        .pop       (!out_stall),
        .not_empty (out_valid),
        .room      (room),
        .head      (head)
    );

    assign token_kind   = head.kind;
    assign number_value = head.value;
    assign start_pos    = head.start_pos;
    assign end_pos      = head.end_pos;
    assign error_code   = head.error_code;
    assign bad_char     = head.bad_char;
    assign last         = head.last;

    // a finish always leaves an end beat in the buffer
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg) |=> out_valid)
        else $error("finish produced no record");

    a_finish_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_reg) |-> (push_cnt != 2'd0))
        else $error("finish pushed nothing");

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (token_kind == mst_pkg::KIND_END))
        else $error("last flag on a non-end record");

    a_token_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last && (token_kind != mst_pkg::KIND_ERROR)) |->
            (error_code == mst_pkg::ERR_NONE))
        else $error("error code on a plain token");

    a_idle_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (push_cnt == 2'd0))
        else $error("records pushed without a beat");

endmodule

FILE: bench/music_script_tokenizer_test.sv
module music_script_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mst_pkg::*;

    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       quick;
        logic       drain;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = 1'b0;
    logic [7:0]  char_code = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [30:0] number_value;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic        last;

    // text waiting to be sent and tokens waiting to come out
    beat_t   text_q[$];
    result_t expected_tokens[$];

    string      symbol_set = "=+-/*[],()";
    logic [7:0] blank_set [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    string      known_words [12] = '{"pattern", "rand", "let", "patter", "patterns", "ran",
                                     "rands", "le", "lets", "Let", "RAND", "pAttern"};

    // tokenizer state as the block should hold it
    lex_mode_t       lx_mode;
    int unsigned     lx_pos;
    int unsigned     lx_start;
    longint unsigned lx_value;
    logic            lx_over;
    string           lx_word;
    error_code_t     lx_error;

    int     fail_count = 0;
    int     total_beats = 0;
    int     beats_taken = 0;
    int     rand_base;
    int     gap_left = 0;
    int     gap_draw;
    int     hold_left = 0;
    int     send_run = 0;
    int     recv_run = 0;
    bit     send_quiet = 1'b0;
    bit     recv_quiet = 1'b0;
    beat_t  next_beat;
    result_t want;
    longint cycle_count = 0;
    longint cycle_limit = 64'd100_000_000;

    music_script_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .number_value (number_value),
        .start_pos    (start_pos),
        .end_pos      (end_pos),
        .error_code   (error_code),
        .bad_char     (bad_char),
        .last         (last)
    );

    always #5 clk = ~clk;

    function automatic bit is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic bit is_decimal(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic bit symbol_token(input logic [7:0] c, output token_kind_t k);
        k = KIND_ID;
        case (c)
            "=": k = KIND_EQUALS;
            "+": k = KIND_ADD;
            "-": k = KIND_SUB;
            "/": k = KIND_DIV;
            "*": k = KIND_MUL;
            "[": k = KIND_LBRACKET;
            "]": k = KIND_RBRACKET;
            ",": k = KIND_COMMA;
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            default: k = KIND_ID;
        endcase
        return k != KIND_ID;
    endfunction

    function automatic void clear_lexer();
        lx_mode  = MODE_IDLE;
        lx_pos   = 0;
        lx_start = 0;
        lx_value = 0;
        lx_over  = 1'b0;
        lx_word  = "";
        lx_error = ERR_NONE;
    endfunction

    function automatic void push_token(input token_kind_t k, input logic [30:0] val,
                                       input int unsigned s, input int unsigned e,
                                       input error_code_t err, input logic [7:0] bad,
                                       input logic lst);
        result_t r;
        r.kind       = k;
        r.value      = val;
        r.start_pos  = s[15:0];
        r.end_pos    = e[15:0];
        r.error_code = err;
        r.bad_char   = bad;
        r.last       = lst;
        expected_tokens = {expected_tokens, r};
    endfunction

    // close the number or word in progress, ending at end_at
    function automatic void flush_lexeme(input int unsigned end_at);
        token_kind_t k;
        if (lx_mode == MODE_NUM)
        begin
            if (lx_over)
            begin
                lx_error = ERR_OVERFLOW;
                lx_mode  = MODE_ERROR;
                push_token(KIND_ERROR, '0, lx_start, end_at, ERR_OVERFLOW, 8'h00, 1'b0);
            end
            else
            begin
                lx_mode = MODE_IDLE;
                push_token(KIND_NUM, lx_value[30:0], lx_start, end_at, ERR_NONE, 8'h00, 1'b0);
            end
        end
        else if (lx_mode == MODE_WORD)
        begin
            // word text is kept to 8 chars, enough to tell keywords apart
            k = KIND_ID;
            if (lx_word == "pattern")
                k = KIND_PATTERN;
            else if (lx_word == "rand")
                k = KIND_RAND;
            else if (lx_word == "let")
                k = KIND_LET;
            lx_mode = MODE_IDLE;
            push_token(k, '0, lx_start, end_at, ERR_NONE, 8'h00, 1'b0);
        end
    endfunction

    function automatic void lex_beat(input logic cmd, input logic [7:0] c);
        int unsigned here;
        token_kind_t sk;
        if (cmd)
        begin
            if (lx_mode == MODE_COMMENT)
            begin
                lx_error = ERR_UNCLOSED;
                push_token(KIND_ERROR, '0, lx_start, lx_pos - 1, ERR_UNCLOSED, 8'h00, 1'b0);
            end
            else
            begin
                flush_lexeme(lx_pos - 1);
            end
            push_token(KIND_END, '0, lx_pos, lx_pos, lx_error, 8'h00, 1'b1);
            clear_lexer();
            return;
        end
        if (lx_pos >= MAX_TEXT_LENGTH)
            return;
        here = lx_pos;
        lx_pos++;
        case (lx_mode)
            MODE_ERROR: return;
            MODE_COMMENT:
            begin
                if (c == "$")
                    lx_mode = MODE_IDLE;
                return;
            end
            MODE_NUM:
            begin
                if (is_decimal(c))
                begin
                    if (!lx_over)
                    begin
                        lx_value = lx_value * 10 + (c - "0");
                        if (lx_value > NUM_MAX)
                            lx_over = 1'b1;
                    end
                    return;
                end
                flush_lexeme(here - 1);
                // the char that ends an overflowed run is swallowed
                if (lx_mode == MODE_ERROR)
                    return;
            end
            MODE_WORD:
            begin
                if (is_letter(c) || is_decimal(c))
                begin
                    if (lx_word.len() < 8)
                        lx_word = $sformatf("%s%c", lx_word, c);
                    return;
                end
                flush_lexeme(here - 1);
            end
            default: ;
        endcase
        if (is_blank(c))
            return;
        if (c == "$")
        begin
            lx_mode  = MODE_COMMENT;
            lx_start = here;
        end
        else if (is_decimal(c))
        begin
            lx_mode  = MODE_NUM;
            lx_start = here;
            lx_value = c - "0";
            lx_over  = 1'b0;
        end
        else if (is_letter(c))
        begin
            lx_mode  = MODE_WORD;
            lx_start = here;
            lx_word  = $sformatf("%c", c);
        end
        else if (symbol_token(c, sk))
        begin
            push_token(sk, '0, here, here, ERR_NONE, 8'h00, 1'b0);
        end
        else
        begin
            lx_mode  = MODE_ERROR;
            lx_error = ERR_UNEXPECTED;
            push_token(KIND_ERROR, '0, here, here, ERR_UNEXPECTED, c, 1'b0);
        end
    endfunction

    function automatic void add_beat(input logic cmd, input logic [7:0] ch, input logic quick);
        beat_t b;
        b.cmd   = cmd;
        b.ch    = ch;
        b.quick = quick;
        b.drain = 1'b0;
        text_q = {text_q, b};
        total_beats++;
    endfunction

    function automatic void add_text(input string s, input logic quick);
        for (int i = 0; i < s.len(); i++)
            add_beat(1'b0, s[i], quick);
    endfunction

    function automatic void add_finish();
        add_beat(1'b1, 8'($urandom), 1'b0);
    endfunction

    // sender holds off until every token so far has come out
    function automatic void add_drain();
        beat_t b;
        b = '0;
        b.drain = 1'b1;
        text_q = {text_q, b};
    endfunction

    function automatic void add_comment(input logic closed);
        logic [7:0] c;
        add_beat(1'b0, "$", 1'b0);
        repeat ($urandom_range(0, 8))
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == "$");
            add_beat(1'b0, c, 1'b0);
        end
        if (closed)
            add_beat(1'b0, "$", 1'b0);
    endfunction

    function automatic void add_random_text();
        int pick;
        int r;
        longint unsigned v;
        string s;
        logic [7:0] c;
        token_kind_t sk;
        // plain noise
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 20))
                add_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            add_finish();
            return;
        end
        repeat ($urandom_range(0, 12))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                case ($urandom_range(0, 11))
                    0:       v = $urandom_range(0, 9);
                    1:       v = $urandom_range(0, 99999);
                    2:       v = $urandom;
                    3:       v = 64'd2147483647;
                    4:       v = 64'd2147483648;
                    5:       v = 64'd2147483600 + $urandom_range(0, 47);
                    6:       v = {$urandom, $urandom};
                    default: v = $urandom_range(0, 999);
                endcase
                s = $sformatf("%0d", v);
                if (pick < 4)
                    s = {"00", s};
                add_text(s, 1'b0);
            end
            else if (pick < 55)
            begin
                if ($urandom_range(0, 1))
                begin
                    s = known_words[$urandom_range(0, 11)];
                end
                else
                begin
                    c = 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
                    s = $sformatf("%c", c);
                    repeat ($urandom_range(0, 17))
                    begin
                        r = $urandom_range(0, 61);
                        c = (r < 10) ? 8'("0" + r) : (r < 36) ? 8'("a" + r - 10)
                                                              : 8'("A" + r - 36);
                        s = $sformatf("%s%c", s, c);
                    end
                end
                add_text(s, 1'b0);
            end
            else if (pick < 82)
            begin
                add_beat(1'b0, symbol_set[$urandom_range(0, 9)], 1'b0);
            end
            else if (pick < 97)
            begin
                add_comment(1'b1);
            end
            else
            begin
                // a byte outside every class
                do
                    c = 8'($urandom_range(0, 255));
                while (is_blank(c) || is_decimal(c) || is_letter(c) || c == "$" ||
                       symbol_token(c, sk));
                add_beat(1'b0, c, 1'b0);
            end
            repeat ($urandom_range(0, 2))
                add_beat(1'b0, blank_set[$urandom_range(0, 5)], 1'b0);
        end
        if ($urandom_range(0, 15) == 0)
            add_comment(1'b0);
        add_finish();
    endfunction

    // wait per beat, in runs that are either busy or gap free
    function automatic int draw_wait(inout int run_left, inout bit quiet);
        if (run_left == 0)
        begin
            run_left = $urandom_range(10, 150);
            quiet    = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got);
        if (got !== exp_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            command   <= 1'b0;
            char_code <= 8'h00;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                lex_beat(command, char_code);
                beats_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (text_q.size() != 0 && text_q[0].drain)
                begin
                    in_valid <= 1'b0;
                    if (expected_tokens.size() == 0)
                        text_q.delete(0);
                end
                else if (text_q.size() != 0)
                begin
                    next_beat = text_q.pop_front();
                    in_valid  <= 1'b1;
                    command   <= next_beat.cmd;
                    char_code <= next_beat.ch;
                    gap_draw = next_beat.quick ? 0 : draw_wait(send_run, send_quiet);
                    gap_left = gap_draw;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: token expected none, got kind %0d start %0d end %0d",
                             $time, token_kind, start_pos, end_pos);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, token_kind);
                    check_field("number_value", want.value, number_value);
                    check_field("start_pos", want.start_pos, start_pos);
                    check_field("end_pos", want.end_pos, end_pos);
                    check_field("error_code", want.error_code, error_code);
                    check_field("bad_char", want.bad_char, bad_char);
                    check_field("last", want.last, last);
                end
                hold_left = draw_wait(recv_run, recv_quiet);
            end
            else if (hold_left == 0 && $urandom_range(0, 31) == 0)
            begin
                hold_left = draw_wait(recv_run, recv_quiet);
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("music_script_tokenizer regression: fail");
            $finish;
        end
    end

    initial
    begin
        clear_lexer();

        // keyword, symbols and a zero
        add_text("rand=(0)", 1'b0);
        add_finish();
        // one past the largest number, then a swallowed comma
        add_text("2147483648,", 1'b0);
        add_finish();
        add_beat(1'b0, 8'hFF, 1'b0);
        add_finish();
        // comment still open at finish
        add_text("$x", 1'b0);
        add_finish();
        // empty text
        add_finish();
        add_drain();

        rand_base = total_beats;
        while (total_beats < rand_base + 1750)
        begin
            add_random_text();
            if ($urandom_range(0, 11) == 0)
                add_drain();
        end
        cycle_limit = 200 * text_q.size() + 100000;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_taken != total_beats || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("music_script_tokenizer regression: pass");
        else
            $display("music_script_tokenizer regression: fail");
        $finish;
    end

endmodule
